// ===== hdl/qrs_pkg.sv =====
// ---------------------------------------------------------------------------
// qrs_pkg
// Shared widths, root kind codes and the sideband word of the quadratic solver.
// ---------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 11;
  localparam int OUT_W     = 27;
  localparam int D_PAIRS   = 12;
  localparam int DISC_W    = 2 * D_PAIRS;

  typedef enum logic [1:0] {
    KIND_DEGEN    = 2'd0,
    KIND_DISTINCT = 2'd1,
    KIND_EQUAL    = 2'd2,
    KIND_COMPLEX  = 2'd3
  } root_kind_e;

  typedef struct packed {
    root_kind_e             kind;
    logic signed [IN_W-1:0] coef_a;
    logic signed [IN_W-1:0] coef_b;
  } side_t;

endpackage

`default_nettype wire

// ===== hdl/qrs_front.sv =====
// ---------------------------------------------------------------------------
// qrs_front
// Two stage discriminant: products, then difference, sign class and magnitude.
// ---------------------------------------------------------------------------
`default_nettype none

module qrs_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic signed [qrs_pkg::IN_W-1:0]   coef_a_i,
  input  wire logic signed [qrs_pkg::IN_W-1:0]   coef_b_i,
  input  wire logic signed [qrs_pkg::IN_W-1:0]   coef_c_i,
  output logic                                   valid_o,
  output logic [qrs_pkg::DISC_W-1:0]             mag_o,
  output qrs_pkg::side_t                         side_o
);
  import qrs_pkg::*;

  localparam int PW = 2 * IN_W;

  logic                   v1_q;
  logic signed [PW-1:0]   bb_q, ac_q;
  logic signed [IN_W-1:0] a1_q, b1_q;

  logic signed [DISC_W-1:0] disc;
  logic [DISC_W-1:0]        mag_d, mag_q;
  side_t                    side_d, side_q;
  logic                     v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q   <= coef_b_i * coef_b_i;
      ac_q   <= coef_a_i * coef_c_i;
      a1_q   <= coef_a_i;
      b1_q   <= coef_b_i;
      mag_q  <= mag_d;
      side_q <= side_d;
    end
  end

  always_comb begin
    disc = DISC_W'(bb_q) - (DISC_W'(ac_q) <<< 2);
    mag_d = disc[DISC_W-1] ? DISC_W'(-disc) : DISC_W'(disc);
    side_d.coef_a = a1_q;
    side_d.coef_b = b1_q;
    if (a1_q == '0) begin
      side_d.kind = KIND_DEGEN;
    end else if (disc[DISC_W-1]) begin
      side_d.kind = KIND_COMPLEX;
    end else if (disc == '0) begin
      side_d.kind = KIND_EQUAL;
    end else begin
      side_d.kind = KIND_DISTINCT;
    end
  end

  assign valid_o = v2_q;
  assign mag_o   = mag_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ===== hdl/qrs_sqrt.sv =====
// ---------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt #(
  parameter int FracBits = qrs_pkg::FRAC_BITS
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      en_i,
  input  wire logic                                      valid_i,
  input  wire logic [qrs_pkg::DISC_W-1:0]                mag_i,
  input  wire qrs_pkg::side_t                            side_i,
  output logic                                           valid_o,
  output logic [qrs_pkg::D_PAIRS+FracBits-1:0]           root_o,
  output logic                                           exact_o,
  output qrs_pkg::side_t                                 side_o
);
  import qrs_pkg::*;

  localparam int N  = D_PAIRS + FracBits;
  localparam int DW = DISC_W;

  logic          vld_q [N];
  logic          vld_d [N];
  logic [DW-1:0] m_q   [N];
  logic [DW-1:0] m_d   [N];
  logic [N-1:0]  root_q[N];
  logic [N-1:0]  root_d[N];
  logic [N+1:0]  rem_q [N];
  logic [N+1:0]  rem_d [N];
  side_t         side_q[N];
  side_t         side_d[N];

  always_comb begin
    logic          v_in;
    logic [DW-1:0] m_in;
    logic [N-1:0]  root_in;
    logic [N+1:0]  rem_in;
    side_t         s_in;
    logic [N+3:0]  acc, trial, diff;
    logic          geq;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        v_in    = valid_i;
        m_in    = mag_i;
        root_in = '0;
        rem_in  = '0;
        s_in    = side_i;
      end else begin
        v_in    = vld_q[i-1];
        m_in    = m_q[i-1];
        root_in = root_q[i-1];
        rem_in  = rem_q[i-1];
        s_in    = side_q[i-1];
      end
      acc       = {rem_in, m_in[DW-1:DW-2]};
      trial     = {2'b00, root_in, 2'b01};
      geq       = (acc >= trial);
      diff      = acc - trial;
      vld_d[i]  = v_in;
      m_d[i]    = m_in << 2;
      root_d[i] = {root_in[N-2:0], geq};
      rem_d[i]  = geq ? diff[N+1:0] : acc[N+1:0];
      side_d[i] = s_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      for (int i = 0; i < N; i++) vld_q[i] <= vld_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        m_q[i]    <= m_d[i];
        root_q[i] <= root_d[i];
        rem_q[i]  <= rem_d[i];
        side_q[i] <= side_d[i];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign exact_o = (rem_q[N-1] == '0);
  assign side_o  = side_q[N-1];

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[N-1] |-> (rem_q[N-1] <= {root_q[N-1], 1'b0}))
    else $error("square root remainder above bound");
`endif

endmodule

`default_nettype wire

// ===== hdl/qrs_div.sv =====
// ---------------------------------------------------------------------------
// qrs_div
// Numerator setup, two-lane pipelined rounding divider and saturating output.
// ---------------------------------------------------------------------------
`default_nettype none

module qrs_div #(
  parameter int FracBits = qrs_pkg::FRAC_BITS
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    en_i,
  input  wire logic                                    valid_i,
  input  wire logic [qrs_pkg::D_PAIRS+FracBits-1:0]    root_i,
  input  wire logic                                    exact_i,
  input  wire qrs_pkg::side_t                          side_i,
  output logic                                         valid_o,
  output qrs_pkg::root_kind_e                          kind_o,
  output logic signed [qrs_pkg::OUT_W-1:0]             first_o,
  output logic signed [qrs_pkg::OUT_W-1:0]             second_o
);
  import qrs_pkg::*;

  localparam int N  = D_PAIRS + FracBits;
  localparam int NW = FracBits + 15;
  localparam int XW = NW + 1;
  localparam int YW = IN_W + 3;
  localparam int CW = ((XW > OUT_W) ? XW : OUT_W) + 1;
  localparam logic [CW-1:0] MaxPos = CW'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [CW-1:0] MaxNeg = CW'(64'd1 << (OUT_W - 1));

  // setup stage
  logic signed [NW-1:0] u2, t2, n0, n1;
  logic [NW-1:0]        an0, an1;
  logic [IN_W-1:0]      am;
  logic signed [IN_W:0] nb;
  logic [XW-1:0]        x0_d, x1_d;

  logic                 pv_q;
  logic [XW-1:0]        px0_q, px1_q;
  logic [YW-1:0]        py_q;
  logic                 pneg0_q, pneg1_q;
  root_kind_e           pkind_q;

  always_comb begin
    nb  = -{side_i.coef_b[IN_W-1], side_i.coef_b};
    u2  = NW'(nb) <<< (FracBits + 1);
    t2  = $signed({{(NW-N-1){1'b0}}, root_i, ~exact_i});
    am  = side_i.coef_a[IN_W-1] ? IN_W'(-side_i.coef_a) : IN_W'(side_i.coef_a);
    n0  = (side_i.kind == KIND_DISTINCT) ? u2 + t2 : u2;
    case (side_i.kind)
      KIND_DISTINCT: n1 = u2 - t2;
      KIND_COMPLEX:  n1 = t2;
      default:       n1 = u2;
    endcase
    an0  = n0[NW-1] ? NW'(-n0) : NW'(n0);
    an1  = n1[NW-1] ? NW'(-n1) : NW'(n1);
    x0_d = {an0, 1'b0} + XW'({am, 2'b00});
    x1_d = {an1, 1'b0} + XW'({am, 2'b00});
  end

  // divider stages
  logic          dv_q  [XW];
  logic          dv_d  [XW];
  logic [XW-1:0] x0_q  [XW];
  logic [XW-1:0] x0_n  [XW];
  logic [XW-1:0] x1_q  [XW];
  logic [XW-1:0] x1_n  [XW];
  logic [YW-1:0] r0_q  [XW];
  logic [YW-1:0] r0_d  [XW];
  logic [YW-1:0] r1_q  [XW];
  logic [YW-1:0] r1_d  [XW];
  logic [XW-1:0] q0_q  [XW];
  logic [XW-1:0] q0_d  [XW];
  logic [XW-1:0] q1_q  [XW];
  logic [XW-1:0] q1_d  [XW];
  logic [YW-1:0] y_q   [XW];
  logic [YW-1:0] y_d   [XW];
  logic          g0_q  [XW];
  logic          g0_d  [XW];
  logic          g1_q  [XW];
  logic          g1_d  [XW];
  root_kind_e    k_q   [XW];
  root_kind_e    k_d   [XW];

  always_comb begin
    logic          v_in, g0_in, g1_in;
    logic [XW-1:0] xa, xb, qa, qb;
    logic [YW-1:0] ra, rb, y_in;
    root_kind_e    k_in;
    logic [YW:0]   acc0, acc1, dif0, dif1;
    logic          ge0, ge1;
    for (int i = 0; i < XW; i++) begin
      if (i == 0) begin
        v_in  = pv_q;
        xa    = px0_q;
        xb    = px1_q;
        ra    = '0;
        rb    = '0;
        qa    = '0;
        qb    = '0;
        y_in  = py_q;
        g0_in = pneg0_q;
        g1_in = pneg1_q;
        k_in  = pkind_q;
      end else begin
        v_in  = dv_q[i-1];
        xa    = x0_q[i-1];
        xb    = x1_q[i-1];
        ra    = r0_q[i-1];
        rb    = r1_q[i-1];
        qa    = q0_q[i-1];
        qb    = q1_q[i-1];
        y_in  = y_q[i-1];
        g0_in = g0_q[i-1];
        g1_in = g1_q[i-1];
        k_in  = k_q[i-1];
      end
      acc0    = {ra, xa[XW-1]};
      acc1    = {rb, xb[XW-1]};
      ge0     = (acc0 >= {1'b0, y_in});
      ge1     = (acc1 >= {1'b0, y_in});
      dif0    = acc0 - {1'b0, y_in};
      dif1    = acc1 - {1'b0, y_in};
      dv_d[i] = v_in;
      x0_n[i] = xa << 1;
      x1_n[i] = xb << 1;
      r0_d[i] = ge0 ? dif0[YW-1:0] : acc0[YW-1:0];
      r1_d[i] = ge1 ? dif1[YW-1:0] : acc1[YW-1:0];
      q0_d[i] = {qa[XW-2:0], ge0};
      q1_d[i] = {qb[XW-2:0], ge1};
      y_d[i]  = y_in;
      g0_d[i] = g0_in;
      g1_d[i] = g1_in;
      k_d[i]  = k_in;
    end
  end

  // saturating output
  logic [CW-1:0]         qe0, qe1, ng0, ng1;
  logic signed [OUT_W-1:0] f_d, s_d, f_q, s_q;
  root_kind_e            ko_q;
  logic                  ov_q;

  always_comb begin
    qe0 = CW'(q0_q[XW-1]);
    qe1 = CW'(q1_q[XW-1]);
    ng0 = CW'(0) - qe0;
    ng1 = CW'(0) - qe1;
    if (g0_q[XW-1]) begin
      f_d = (qe0 > MaxNeg) ? $signed(MaxNeg[OUT_W-1:0]) : $signed(ng0[OUT_W-1:0]);
    end else begin
      f_d = (qe0 > MaxPos) ? $signed(MaxPos[OUT_W-1:0]) : $signed(qe0[OUT_W-1:0]);
    end
    if (g1_q[XW-1]) begin
      s_d = (qe1 > MaxNeg) ? $signed(MaxNeg[OUT_W-1:0]) : $signed(ng1[OUT_W-1:0]);
    end else begin
      s_d = (qe1 > MaxPos) ? $signed(MaxPos[OUT_W-1:0]) : $signed(qe1[OUT_W-1:0]);
    end
    if (k_q[XW-1] == KIND_DEGEN) begin
      f_d = '0;
      s_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
      for (int i = 0; i < XW; i++) dv_q[i] <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
      ov_q <= dv_q[XW-1];
      for (int i = 0; i < XW; i++) dv_q[i] <= dv_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px0_q   <= x0_d;
      px1_q   <= x1_d;
      py_q    <= {am, 3'b000};
      pneg0_q <= n0[NW-1] ^ side_i.coef_a[IN_W-1];
      pneg1_q <= n1[NW-1] ^ side_i.coef_a[IN_W-1];
      pkind_q <= side_i.kind;
      for (int i = 0; i < XW; i++) begin
        x0_q[i] <= x0_n[i];
        x1_q[i] <= x1_n[i];
        r0_q[i] <= r0_d[i];
        r1_q[i] <= r1_d[i];
        q0_q[i] <= q0_d[i];
        q1_q[i] <= q1_d[i];
        y_q[i]  <= y_d[i];
        g0_q[i] <= g0_d[i];
        g1_q[i] <= g1_d[i];
        k_q[i]  <= k_d[i];
      end
      f_q  <= f_d;
      s_q  <= s_d;
      ko_q <= k_q[XW-1];
    end
  end

  assign valid_o  = ov_q;
  assign kind_o   = ko_q;
  assign first_o  = f_q;
  assign second_o = s_q;

`ifndef NO_ASSERTIONS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ko_q == KIND_DEGEN) |-> (f_q == '0 && s_q == '0))
    else $error("degenerate word with nonzero values");
  a_equal_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ko_q == KIND_EQUAL) |-> (f_q == s_q))
    else $error("equal roots differ");
`endif

endmodule

`default_nettype wire

// ===== hdl/quadratic_root_solver.sv =====
// ---------------------------------------------------------------------------
// quadratic_root_solver
// Fixed-point roots of a*x^2 + b*x + c with exact discriminant and rounding.
// ---------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o carry one word of coefficients
// a, b, c. Output channel: out_valid_o / out_ready_i carry root_kind_o and
// two signed values with FracBits fraction bits.
// The pipeline holds two discriminant stages, one square root stage per
// result bit, one setup stage, one divider stage per numerator bit and one
// output stage.
// Throughput is one word per cycle while the receiver does not stall.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver #(
  parameter int FracBits = qrs_pkg::FRAC_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [qrs_pkg::IN_W-1:0]  coef_a_i,
  input  wire logic signed [qrs_pkg::IN_W-1:0]  coef_b_i,
  input  wire logic signed [qrs_pkg::IN_W-1:0]  coef_c_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0]                            root_kind_o,
  output logic signed [qrs_pkg::OUT_W-1:0]      first_value_o,
  output logic signed [qrs_pkg::OUT_W-1:0]      second_value_o
);
  import qrs_pkg::*;

  localparam int N = D_PAIRS + FracBits;

  logic              adv;
  logic              f_valid, s_valid;
  logic [DISC_W-1:0] f_mag;
  side_t             f_side, s_side;
  logic [N-1:0]      s_root;
  logic              s_exact;
  root_kind_e        kind;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  qrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (in_valid_i),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .valid_o  (f_valid),
    .mag_o    (f_mag),
    .side_o   (f_side)
  );

  qrs_sqrt #(.FracBits(FracBits)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_valid),
    .mag_i   (f_mag),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .exact_o (s_exact),
    .side_o  (s_side)
  );

  qrs_div #(.FracBits(FracBits)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (s_valid),
    .root_i   (s_root),
    .exact_i  (s_exact),
    .side_i   (s_side),
    .valid_o  (out_valid_o),
    .kind_o   (kind),
    .first_o  (first_value_o),
    .second_o (second_value_o)
  );

  assign root_kind_o = kind;

endmodule

`default_nettype wire

// ===== sim/tb_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_checker
// Watches both channels of the quadratic solver, computes the expected roots
// of every accepted coefficient word and compares them in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_ready_i,
  input  wire logic signed [qrs_pkg::IN_W-1:0]  coef_a_i,
  input  wire logic signed [qrs_pkg::IN_W-1:0]  coef_b_i,
  input  wire logic signed [qrs_pkg::IN_W-1:0]  coef_c_i,
  input  wire logic                             out_valid_i,
  input  wire logic                             out_ready_i,
  input  wire logic [1:0]                       root_kind_i,
  input  wire logic signed [qrs_pkg::OUT_W-1:0] first_value_i,
  input  wire logic signed [qrs_pkg::OUT_W-1:0] second_value_i,
  output int                                    fail_cnt_o,
  output int                                    pending_o
);
  import qrs_pkg::*;

  typedef struct packed {
    root_kind_e              kind;
    logic signed [OUT_W-1:0] first;
    logic signed [OUT_W-1:0] second;
  } roots_t;

  roots_t roots_q[$];

  // floor(sqrt(d) * 2^FRAC_BITS), exact flag
  function automatic longint unsigned scaled_sqrt(input longint unsigned d, output bit exact);
    longint unsigned root, rem, pair, trial;
    root = 0;
    rem  = 0;
    for (int j = D_PAIRS + FRAC_BITS - 1; j >= 0; j--) begin
      pair = (j >= FRAC_BITS) ? ((d >> (2 * (j - FRAC_BITS))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    exact = (rem == 0);
    return root;
  endfunction

  // rounded quotient, ties away from zero, saturated to the output width
  function automatic logic signed [OUT_W-1:0] round_sat(input longint n, input longint d);
    longint unsigned an, ad, q;
    longint v;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    v = ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    if (v > (64'sd1 <<< (OUT_W - 1)) - 1) v = (64'sd1 <<< (OUT_W - 1)) - 1;
    if (v < -(64'sd1 <<< (OUT_W - 1))) v = -(64'sd1 <<< (OUT_W - 1));
    return v[OUT_W-1:0];
  endfunction

  function automatic roots_t solve_roots(input longint a, input longint b, input longint c);
    roots_t r;
    longint disc, u2, t2;
    longint unsigned k;
    bit exact;
    r = '0;
    if (a == 0) begin
      r.kind = KIND_DEGEN;
      return r;
    end
    disc = b * b - 4 * a * c;
    u2 = -b * (64'sd1 <<< (FRAC_BITS + 1));
    if (disc > 0) begin
      k = scaled_sqrt(disc, exact);
      t2 = 2 * k + (exact ? 0 : 1);
      r.kind   = KIND_DISTINCT;
      r.first  = round_sat(u2 + t2, 4 * a);
      r.second = round_sat(u2 - t2, 4 * a);
    end else if (disc == 0) begin
      r.kind   = KIND_EQUAL;
      r.first  = round_sat(u2, 4 * a);
      r.second = r.first;
    end else begin
      k = scaled_sqrt(-disc, exact);
      t2 = 2 * k + (exact ? 0 : 1);
      r.kind   = KIND_COMPLEX;
      r.first  = round_sat(u2, 4 * a);
      r.second = round_sat(t2, 4 * a);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    roots_t exp_r;
    int     errs;
    errs = 0;
    if (!rst_ni) begin
      roots_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        roots_q.push_back(solve_roots(coef_a_i, coef_b_i, coef_c_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (roots_q.size() == 0) begin
          $error("unexpected result word");
          errs = errs + 1;
        end else begin
          exp_r = roots_q.pop_front();
          if (root_kind_i != exp_r.kind) begin
            $error("root_kind: expected %0d actual %0d", exp_r.kind, root_kind_i);
            errs = errs + 1;
          end
          if (first_value_i != exp_r.first) begin
            $error("first_value: expected %0d actual %0d", exp_r.first, first_value_i);
            errs = errs + 1;
          end
          if (second_value_i != exp_r.second) begin
            $error("second_value: expected %0d actual %0d", exp_r.second, second_value_i);
            errs = errs + 1;
          end
        end
      end
      fail_cnt_o <= fail_cnt_o + errs;
      pending_o  <= roots_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives directed and random coefficient words into the quadratic solver
// with random idling on both sides and reports the checker's verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import qrs_pkg::*;

  localparam int LATENCY   = 64;
  localparam int NUM_RAND  = 1950;
  localparam int MAX_CYCLE = 200000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [IN_W-1:0]  coef_a;
  logic signed [IN_W-1:0]  coef_b;
  logic signed [IN_W-1:0]  coef_c;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              root_kind;
  logic signed [OUT_W-1:0] first_value;
  logic signed [OUT_W-1:0] second_value;
  int                      fail_cnt;
  int                      pending;
  int                      cycle_cnt;

  quadratic_root_solver u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .coef_a_i      (coef_a),
    .coef_b_i      (coef_b),
    .coef_c_i      (coef_c),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .root_kind_o   (root_kind),
    .first_value_o (first_value),
    .second_value_o(second_value)
  );

  tb_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .coef_a_i      (coef_a),
    .coef_b_i      (coef_b),
    .coef_c_i      (coef_c),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .root_kind_i   (root_kind),
    .first_value_i (first_value),
    .second_value_i(second_value),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver stall, drawn per word
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid && out_ready);
    end
  end

  task automatic send_word(input int a, input int b, input int c, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    coef_a   <= IN_W'(a);
    coef_b   <= IN_W'(b);
    coef_c   <= IN_W'(c);
    @(posedge clk iff in_ready);
  endtask

  function automatic int rand_coef();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2047) - 1024;
      1:       return $urandom_range(0, 10) - 5;
      2:       return ($urandom_range(0, 1) ? 1023 : -1024);
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  initial begin
    int a, b, c, r;
    bit idle;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    coef_a    = '0;
    coef_b    = '0;
    coef_c    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate, extremes, equal roots, complex, exact and inexact roots
    send_word(0, 5, 7, 1'b0);
    send_word(0, 0, 0, 1'b0);
    send_word(1, -2, 1, 1'b0);
    send_word(-3, 12, -12, 1'b0);
    send_word(1, 0, 1, 1'b0);
    send_word(1, 0, -4, 1'b0);
    send_word(1, 0, -2, 1'b0);
    send_word(2, 3, -5, 1'b0);
    send_word(1023, 1023, 1023, 1'b0);
    send_word(-1024, -1024, -1024, 1'b0);
    send_word(1, -1024, -1024, 1'b0);
    send_word(1, 1023, 1023, 1'b0);
    send_word(-1, -1024, 1023, 1'b0);
    send_word(1, -1024, 1023, 1'b0);
    send_word(-1024, 1023, 1023, 1'b0);
    send_word(1023, -1024, -1024, 1'b0);
    send_word(1, 1, 0, 1'b0);
    send_word(4, 4, 1, 1'b0);
    send_word(1024 - 1, 0, -1024, 1'b0);
    send_word(-1, 0, -1024, 1'b0);
    send_word(3, 1, 5, 1'b0);
    in_valid <= 1'b0;

    // hold off until every result is back
    @(posedge clk iff pending == 0);

    for (int i = 0; i < NUM_RAND; i++) begin
      idle = (i % 400) < 300;
      a = rand_coef();
      b = rand_coef();
      if ($urandom_range(0, 4) == 0 && a != 0) begin
        // aim for a zero discriminant where it divides out
        r = $urandom_range(0, 40) - 20;
        b = 2 * a * r;
        c = a * r * r;
        if (b > 1023 || b < -1024 || c > 1023 || c < -1024) c = rand_coef();
        if (b > 1023 || b < -1024) b = rand_coef();
      end else begin
        c = rand_coef();
      end
      send_word(a, b, c, idle);
    end
    in_valid <= 1'b0;

    @(posedge clk iff pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
